FILE: rtl/core/lsr_pkg.sv
// Package for the local alignment row scorer: sizes, codes and transaction types.
`default_nettype none
package lsr_pkg;

    // Array sizes and score width
    localparam int COLS_MAX    = 64;
    localparam int ALPHA_MAX   = 16;
    localparam int SCORE_WIDTH = 16;

    localparam int COL_AW   = $clog2(COLS_MAX);
    localparam int POS_W    = $clog2(ALPHA_MAX);
    localparam int ASIZE_W  = 5;
    localparam int TABLE_D  = ALPHA_MAX * ALPHA_MAX;
    localparam int TABLE_AW = $clog2(TABLE_D);
    localparam int EXT_W    = SCORE_WIDTH + 2;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 8;

    // Commands carried by an input transaction
    typedef enum logic [2:0] {
        CMD_SET_SUB   = 3'd0,
        CMD_SET_ALPHA = 3'd1,
        CMD_SET_REF   = 3'd2,
        CMD_BEGIN     = 3'd3,
        CMD_ROW       = 3'd4
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_GAP   = 2'd0,
        CFG_ALPHA = 2'd1,
        CFG_LEN   = 2'd2
    } cfg_idx_t;

    // Traceback codes
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_DIAG = 2'd1,
        DIR_UP   = 2'd2,
        DIR_LEFT = 2'd3
    } dir_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [7:0]        index;
        logic [7:0]        symbol;
        logic signed [7:0] sub_score;
    } item_t;

    typedef struct packed {
        logic [6:0]  column;
        logic [15:0] cell_score;
        logic [1:0]  direction;
        logic [15:0] best_score;
        logic [15:0] best_row;
        logic [6:0]  best_col;
        logic        unknown_symbol;
        logic        last;
    } result_t;

    // Operands of the shared cell unit
    typedef struct packed {
        logic [SCORE_WIDTH-1:0] diag;
        logic [SCORE_WIDTH-1:0] up;
        logic [SCORE_WIDTH-1:0] left;
        logic signed [7:0]      sub;
        logic signed [7:0]      gap;
        logic [SCORE_WIDTH-1:0] best;
    } cell_op_t;

    // Cell unit results
    typedef struct packed {
        logic [SCORE_WIDTH-1:0] score;
        dir_t                   dir;
        logic                   better;
    } cell_res_t;

endpackage
`default_nettype wire

FILE: rtl/core/lsr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/lsr_alphabet.sv
// Alphabet letter store with a shared letter-position lookup.
`default_nettype none
module lsr_alphabet
    import lsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [POS_W-1:0]   waddr,
    input  wire logic [7:0]         wdata,
    input  wire logic [ASIZE_W-1:0] size,
    input  wire logic [7:0]         sym,
    output logic                    hit,
    output logic      [POS_W-1:0]   pos
);

    logic [7:0] letter_reg [ALPHA_MAX];

    // Letter writes, no reset
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            letter_reg[waddr] <= wdata;
        end
    end

    // Compare every lane; highest matching position in use wins
    always_comb
    begin
        hit = 1'b0;
        pos = '0;
        for (int i = 0; i < ALPHA_MAX; i++)
        begin
            if ((ASIZE_W'(i) < size) && (letter_reg[i] == sym))
            begin
                hit = 1'b1;
                pos = POS_W'(i);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/lsr_cell.sv
// Shared cell unit: three-way max against zero, traceback code, saturation, best test.
`default_nettype none
module lsr_cell
    import lsr_pkg::*;
(
    input  wire cell_op_t  op,
    output cell_res_t      res
);

    localparam logic signed [EXT_W-1:0] SMAX = {2'b00, {SCORE_WIDTH{1'b1}}};

    logic signed [EXT_W-1:0] dg;
    logic signed [EXT_W-1:0] up;
    logic signed [EXT_W-1:0] lf;
    logic signed [EXT_W-1:0] mx;

    always_comb
    begin
        dg = $signed({2'b00, op.diag}) + {{(EXT_W-8){op.sub[7]}}, op.sub};
        up = $signed({2'b00, op.up})   + {{(EXT_W-8){op.gap[7]}}, op.gap};
        lf = $signed({2'b00, op.left}) + {{(EXT_W-8){op.gap[7]}}, op.gap};

        // Largest of zero and the three moves
        mx = '0;
        if (dg > mx)
        begin
            mx = dg;
        end
        if (up > mx)
        begin
            mx = up;
        end
        if (lf > mx)
        begin
            mx = lf;
        end

        // Ties: stop, then diagonal, then up
        priority if (mx == '0)
        begin
            res.dir = DIR_STOP;
        end
        else if (mx == dg)
        begin
            res.dir = DIR_DIAG;
        end
        else if (mx == up)
        begin
            res.dir = DIR_UP;
        end
        else
        begin
            res.dir = DIR_LEFT;
        end

        res.score  = (mx > SMAX) ? {SCORE_WIDTH{1'b1}} : mx[SCORE_WIDTH-1:0];
        res.better = (res.score > op.best);
    end

endmodule
`default_nettype wire

FILE: rtl/core/local_alignment_row_scorer.sv
// Top level of the local alignment row scorer: sequencer, stores and result register.
//
// Load commands (substitution entry, alphabet letter, reference symbol) and
// begin produce no result. A score-row transaction emits one result per
// reference column, left to right, and keeps the block busy until the last
// one is committed, stalling while the result side holds a result back:
// each cell walks a three-step sequence (reference and previous-row memory
// read, letter lookup with substitution memory read, then the shared cell
// unit and write-back). Begin clears the 64 previous-row valid flags at once,
// so no clearing pass is needed after reset or begin.
`default_nettype none
module local_alignment_row_scorer
    import lsr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire item_t             item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output result_t                result,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ROW    = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_LOOKUP = 5'b01000,
        ST_CELL   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic signed [7:0]      gap_reg;
    logic [ASIZE_W-1:0]     asize_reg;
    logic [6:0]             len_reg;
    logic [COL_AW-1:0]      col_reg;
    logic [7:0]             qsym_reg;
    logic                   qhit_reg;
    logic [POS_W-1:0]       qpos_reg;
    logic                   unknown_reg;
    logic [SCORE_WIDTH-1:0] left_reg;
    logic [SCORE_WIDTH-1:0] diag_reg;
    logic [15:0]            row_cnt_reg;
    logic [SCORE_WIDTH-1:0] best_val_reg;
    logic [15:0]            best_row_reg;
    logic [6:0]             best_col_reg;
    logic [COLS_MAX-1:0]    pvalid_reg;
    logic                   result_valid_reg;
    result_t                result_reg;

    logic                   accept;
    logic                   commit;
    logic                   last_col;
    logic [ASIZE_W-1:0]     asize_eff;
    logic [6:0]             cols_m1;
    logic [7:0]             look_sym;
    logic                   look_hit;
    logic [POS_W-1:0]       look_pos;
    logic [TABLE_AW-1:0]    taddr;
    logic [7:0]             ref_rdata;
    logic [SCORE_WIDTH-1:0] prev_rdata;
    logic [7:0]             sub_rdata;
    logic [SCORE_WIDTH-1:0] up_raw;
    cell_op_t               cop;
    cell_res_t              cres;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Effective alphabet size and last column
    assign asize_eff = (asize_reg > ASIZE_W'(ALPHA_MAX)) ? ASIZE_W'(ALPHA_MAX) : asize_reg;
    always_comb
    begin
        priority if (len_reg == 7'd0)
        begin
            cols_m1 = 7'd0;
        end
        else if (len_reg > 7'(COLS_MAX))
        begin
            cols_m1 = 7'(COLS_MAX - 1);
        end
        else
        begin
            cols_m1 = len_reg - 7'd1;
        end
    end
    assign last_col = (7'(col_reg) == cols_m1);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= -8'sd2;
            asize_reg <= 5'd4;
            len_reg   <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAP:   gap_reg   <= $signed(cfg_data);
                CFG_ALPHA: asize_reg <= cfg_data[ASIZE_W-1:0];
                CFG_LEN:   len_reg   <= cfg_data[6:0];
                default:   ;
            endcase
        end
    end

    // Shared letter lookup: query symbol at row start, reference symbol per cell
    assign look_sym = (state_reg == ST_ROW) ? qsym_reg : ref_rdata;

    lsr_alphabet u_alpha (
        .clk   (clk),
        .we    (accept && (item.cmd == CMD_SET_ALPHA) && (item.index[7:POS_W] == '0)),
        .waddr (item.index[POS_W-1:0]),
        .wdata (item.symbol),
        .size  (asize_eff),
        .sym   (look_sym),
        .hit   (look_hit),
        .pos   (look_pos)
    );

    // Substitution table address a * size + b, always below the table depth
    assign taddr = TABLE_AW'(qpos_reg) * TABLE_AW'(asize_eff) + TABLE_AW'(look_pos);

    lsr_ram #(.WIDTH(8), .DEPTH(TABLE_D)) u_sub_ram (
        .clk   (clk),
        .we    (accept && (item.cmd == CMD_SET_SUB)),
        .waddr (item.index[TABLE_AW-1:0]),
        .wdata (item.sub_score),
        .re    (state_reg == ST_LOOKUP),
        .raddr (taddr),
        .rdata (sub_rdata)
    );

    lsr_ram #(.WIDTH(8), .DEPTH(COLS_MAX)) u_ref_ram (
        .clk   (clk),
        .we    (accept && (item.cmd == CMD_SET_REF) && (item.index[7:COL_AW] == '0)),
        .waddr (item.index[COL_AW-1:0]),
        .wdata (item.symbol),
        .re    (state_reg == ST_FETCH),
        .raddr (col_reg),
        .rdata (ref_rdata)
    );

    lsr_ram #(.WIDTH(SCORE_WIDTH), .DEPTH(COLS_MAX)) u_prev_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (col_reg),
        .wdata (cres.score),
        .re    (state_reg == ST_FETCH),
        .raddr (col_reg),
        .rdata (prev_rdata)
    );

    // Cell operands
    assign up_raw = pvalid_reg[col_reg] ? prev_rdata : '0;
    always_comb
    begin
        cop.diag = diag_reg;
        cop.up   = up_raw;
        cop.left = left_reg;
        cop.sub  = unknown_reg ? 8'sd0 : $signed(sub_rdata);
        cop.gap  = gap_reg;
        cop.best = best_val_reg;
    end

    lsr_cell u_cell (
        .op  (cop),
        .res (cres)
    );

    assign commit = (state_reg == ST_CELL) && (!result_valid_reg || result_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_ROW))
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:    state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_CELL;
            ST_CELL:
            begin
                if (commit)
                begin
                    state_next = last_col ? ST_IDLE : ST_FETCH;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Row and best-score state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            best_val_reg <= '0;
            best_row_reg <= '0;
            best_col_reg <= '0;
            pvalid_reg   <= '0;
            col_reg      <= '0;
        end
        else
        begin
            if (accept && (item.cmd == CMD_BEGIN))
            begin
                row_cnt_reg  <= '0;
                best_val_reg <= '0;
                best_row_reg <= '0;
                best_col_reg <= '0;
                pvalid_reg   <= '0;
            end
            if (state_reg == ST_ROW)
            begin
                col_reg <= '0;
                if (row_cnt_reg != 16'hFFFF)
                begin
                    row_cnt_reg <= row_cnt_reg + 16'd1;
                end
            end
            if (commit)
            begin
                pvalid_reg[col_reg] <= 1'b1;
                col_reg             <= col_reg + COL_AW'(1);
                if (cres.better)
                begin
                    best_val_reg <= cres.score;
                    best_row_reg <= row_cnt_reg;
                    best_col_reg <= 7'(col_reg) + 7'd1;
                end
            end
        end
    end

    // Per-row datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qsym_reg <= item.symbol;
        end
        if (state_reg == ST_ROW)
        begin
            qhit_reg <= look_hit;
            qpos_reg <= look_pos;
            left_reg <= '0;
            diag_reg <= '0;
        end
        if (state_reg == ST_LOOKUP)
        begin
            unknown_reg <= !(qhit_reg && look_hit);
        end
        if (commit)
        begin
            left_reg <= cres.score;
            diag_reg <= up_raw;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            result_reg.column         <= 7'(col_reg) + 7'd1;
            result_reg.cell_score     <= cres.score;
            result_reg.direction      <= cres.dir;
            result_reg.best_score     <= cres.better ? cres.score : best_val_reg;
            result_reg.best_row       <= cres.better ? row_cnt_reg : best_row_reg;
            result_reg.best_col       <= cres.better ? (7'(col_reg) + 7'd1) : best_col_reg;
            result_reg.unknown_symbol <= unknown_reg;
            result_reg.last           <= last_col;
        end
    end

`ifndef SYNTHESIS
    // Finishing the last column returns the block to accepting input
    a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && last_col) |=> item_ready)
        else $error("row did not end after last column");

    // Columns advance by one per committed cell
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !last_col) |=> (col_reg == $past(col_reg) + COL_AW'(1)))
        else $error("column counter skipped");

    // Best score never drops while a row is in progress
    a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (best_val_reg >= $past(best_val_reg)))
        else $error("best score decreased within a row");

    // A cell is only committed into a free result slot
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> $stable(result_reg))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the local alignment row scorer.
`timescale 1ns / 100ps

module tb
    import lsr_pkg::*;
;

    // Idle cycles after the last cell of a row
    localparam int DRAIN_CYCLES   = 200;
    // Cycles without any accepted transaction before the run is abandoned
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SCORE_MAX      = (1 << SCORE_WIDTH) - 1;
    localparam int ROW_CAP        = 65535;
    // Command codes the block ignores
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam logic [7:0] LETTER_BASE     = 8'h41;
    localparam logic [7:0] NOT_A_LETTER    = 8'hFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              item_valid = 1'b0;
    logic              item_ready;
    item_t             item_in = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result_out;
    logic              cfg_we = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    local_alignment_row_scorer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scoring model state
    logic signed [7:0] sub_tab [TABLE_D];
    logic [7:0]        letters [ALPHA_MAX];
    logic [7:0]        ref_syms [COLS_MAX];
    int                prev_row [COLS_MAX];
    int                row_cnt = 0;
    int                best_val = 0;
    int                best_r = 0;
    int                best_c = 0;
    logic signed [7:0] gap_pen = -8'sd2;
    logic [4:0]        asize = 5'd4;
    logic [6:0]        rlen = 7'd64;

    result_t expected_cells [$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;

    // Receiver stall pattern state
    int          ready_mode = 0;
    int          mode_left = 0;
    int          ready_phase = 0;
    logic [31:0] ready_pat = 32'hFFFF_FFFF;

    function automatic int eff_alpha();
        return (asize > ALPHA_MAX) ? ALPHA_MAX : int'(asize);
    endfunction

    // Highest alphabet position holding the byte, -1 if absent
    function automatic int letter_pos(logic [7:0] s);
        int found;
        int n;
        found = -1;
        n = eff_alpha();
        for (int i = 0; i < n; i++)
            if (letters[i] == s)
                found = i;
        return found;
    endfunction

    // Score one grid row and queue one expected cell per column
    function automatic void score_row(logic [7:0] qsym);
        int cols, na, qpos, rpos, t;
        int diag_prev, left, up, dg, lf, score, sub;
        bit unk;
        dir_t dir;
        result_t r;
        cols = (rlen < 1) ? 1 : ((rlen > COLS_MAX) ? COLS_MAX : int'(rlen));
        if (row_cnt < ROW_CAP)
            row_cnt++;
        na = eff_alpha();
        qpos = letter_pos(qsym);
        diag_prev = 0;
        left = 0;
        for (int j = 0; j < cols; j++)
        begin
            rpos = letter_pos(ref_syms[j]);
            unk = (qpos < 0) || (rpos < 0);
            sub = 0;
            if (!unk)
            begin
                t = qpos * na + rpos;
                if (t < TABLE_D)
                    sub = int'(sub_tab[t]);
            end
            dg = diag_prev + sub;
            lf = left + int'(gap_pen);
            up = prev_row[j] + int'(gap_pen);

            score = 0;
            if (dg > score) score = dg;
            if (up > score) score = up;
            if (lf > score) score = lf;
            // ties resolve stop, diagonal, up, left
            if (score == 0)       dir = DIR_STOP;
            else if (score == dg) dir = DIR_DIAG;
            else if (score == up) dir = DIR_UP;
            else                  dir = DIR_LEFT;
            if (score > SCORE_MAX)
                score = SCORE_MAX;

            diag_prev = prev_row[j];
            prev_row[j] = score;
            left = score;

            // only a strictly higher score moves the best
            if (score > best_val)
            begin
                best_val = score;
                best_r = row_cnt;
                best_c = j + 1;
            end

            r.column         = 7'(j + 1);
            r.cell_score     = 16'(score);
            r.direction      = dir;
            r.best_score     = 16'(best_val);
            r.best_row       = 16'(best_r);
            r.best_col       = 7'(best_c);
            r.unknown_symbol = unk;
            r.last           = (j + 1 == cols);
            expected_cells.push_back(r);
        end
    endfunction

    // Update the model for one accepted input transaction
    function automatic void apply_item(item_t it);
        case (it.cmd)
            CMD_SET_SUB:
                sub_tab[it.index] = it.sub_score;
            CMD_SET_ALPHA:
                if (it.index < ALPHA_MAX)
                    letters[it.index] = it.symbol;
            CMD_SET_REF:
                if (it.index < COLS_MAX)
                    ref_syms[it.index] = it.symbol;
            CMD_BEGIN:
            begin
                foreach (prev_row[k])
                    prev_row[k] = 0;
                row_cnt = 0;
                best_val = 0;
                best_r = 0;
                best_c = 0;
            end
            CMD_ROW:
                score_row(it.symbol);
            default: ;
        endcase
    endfunction

    // Drive one input transaction, then keep the burst going or open a gap
    task automatic send_item(input item_t it);
        item_valid <= 1'b1;
        item_in <= it;
        do @(posedge clk); while (!item_ready);
        apply_item(it);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send_fields(input logic [2:0] c, input logic [7:0] idx,
                               input logic [7:0] sym, input logic [7:0] sc);
        item_t it;
        it.cmd = c;
        it.index = idx;
        it.symbol = sym;
        it.sub_score = sc;
        send_item(it);
    endtask

    // Hold the sender until every cell has come back and the block is quiet
    task automatic wait_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_cells.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_DW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_GAP:   gap_pen = data;
            CFG_ALPHA: asize = data[4:0];
            CFG_LEN:   rlen = data[6:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] gap, input logic [7:0] na,
                              input logic [7:0] len);
        write_cfg(CFG_GAP, gap);
        write_cfg(CFG_ALPHA, na);
        write_cfg(CFG_LEN, len);
    endtask

    // Random traffic: mostly well-formed loads and rows, some noise
    function automatic item_t next_traffic_item();
        item_t it;
        int roll, na;
        na = eff_alpha();
        roll = $urandom_range(0, 99);
        it.index = 8'($urandom);
        it.symbol = 8'($urandom);
        it.sub_score = 8'($urandom);
        if (roll < 45)
        begin
            it.cmd = CMD_ROW;
            if (na > 0 && $urandom_range(0, 9) < 8)
                it.symbol = letters[$urandom_range(0, na - 1)];
        end
        else if (roll < 60)
        begin
            it.cmd = CMD_SET_SUB;
            if (na > 0 && $urandom_range(0, 9) < 8)
                it.index = 8'($urandom_range(0, na * na - 1));
        end
        else if (roll < 70)
        begin
            it.cmd = CMD_SET_ALPHA;
            if ($urandom_range(0, 99) < 85)
                it.index = 8'($urandom_range(0, ALPHA_MAX - 1));
            if ($urandom_range(0, 1))
                it.symbol = LETTER_BASE + 8'($urandom_range(0, 7));
        end
        else if (roll < 85)
        begin
            it.cmd = CMD_SET_REF;
            if ($urandom_range(0, 99) < 85)
                it.index = 8'($urandom_range(0, COLS_MAX - 1));
            if (na > 0 && $urandom_range(0, 9) < 7)
                it.symbol = letters[$urandom_range(0, na - 1)];
        end
        else if (roll < 93)
            it.cmd = CMD_BEGIN;
        else
            it.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        return it;
    endfunction

    // Fill every store entry once so no row ever reads an unwritten one
    task automatic test_load_stores();
        for (int i = 0; i < ALPHA_MAX; i++)
            send_fields(CMD_SET_ALPHA, 8'(i), LETTER_BASE + 8'(i), 8'($urandom));
        for (int i = 0; i < COLS_MAX; i++)
            send_fields(CMD_SET_REF, 8'(i), LETTER_BASE + 8'($urandom_range(0, 3)),
                        8'($urandom));
        for (int i = 0; i < TABLE_D; i++)
            send_fields(CMD_SET_SUB, 8'(i), 8'($urandom), 8'($urandom));
    endtask

    // Rows under the reset configuration, known and unknown query
    task automatic test_reset_defaults();
        send_fields(CMD_ROW, 8'd0, LETTER_BASE, 8'd0);
        send_fields(CMD_ROW, 8'd0, NOT_A_LETTER, 8'd0);
        send_fields(CMD_ROW, 8'd0, LETTER_BASE + 8'd2, 8'd0);
    endtask

    // Every command, duplicate letters, ignored writes and spare codes
    task automatic test_commands();
        wait_idle();
        set_config(8'hFF, 8'd8, 8'd8);
        send_fields(CMD_SET_ALPHA, 8'd3, LETTER_BASE + 8'd1, 8'd0);
        send_fields(CMD_SET_REF, 8'd0, LETTER_BASE + 8'd1, 8'd0);
        send_fields(CMD_SET_REF, 8'd1, LETTER_BASE + 8'd2, 8'd0);
        send_fields(CMD_SET_REF, 8'd2, NOT_A_LETTER, 8'd0);
        send_fields(CMD_SET_SUB, 8'd27, 8'd0, 8'sd127);
        send_fields(CMD_SET_SUB, 8'd26, 8'd0, -8'sd128);
        send_fields(CMD_SET_SUB, 8'd255, 8'd0, 8'sd127);
        send_fields(CMD_SET_ALPHA, 8'd200, LETTER_BASE + 8'd2, 8'd0);
        send_fields(CMD_SET_REF, 8'd255, LETTER_BASE, 8'd0);
        send_fields(CMD_SET_REF, 8'd64, LETTER_BASE, 8'd0);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_fields(3'(c), 8'hFF, 8'hFF, 8'hFF);
        send_fields(CMD_BEGIN, 8'd0, 8'd0, 8'd0);
        send_fields(CMD_ROW, 8'd0, LETTER_BASE + 8'd1, 8'd0);
        send_fields(CMD_ROW, 8'd0, LETTER_BASE + 8'd1, 8'd0);
        send_fields(CMD_ROW, 8'd0, NOT_A_LETTER, 8'd0);
        send_fields(CMD_ROW, 8'd0, LETTER_BASE + 8'd2, 8'd0);
    endtask

    // Gap, alphabet size and length at and beyond their limits
    task automatic test_config_extremes();
        logic [7:0] gaps [4]  = '{8'h80, 8'h7F, 8'h00, 8'hFF};
        logic [7:0] sizes [4] = '{8'd0, 8'd31, 8'd1, 8'd16};
        logic [7:0] lens [4]  = '{8'd0, 8'd127, 8'd1, 8'd64};
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            set_config(gaps[p], sizes[p], lens[p]);
            send_fields(CMD_BEGIN, 8'd0, 8'd0, 8'd0);
            send_fields(CMD_ROW, 8'd0, LETTER_BASE, 8'd0);
            send_fields(CMD_ROW, 8'd0, letters[$urandom_range(0, ALPHA_MAX - 1)], 8'd0);
            send_fields(CMD_ROW, 8'd0, 8'($urandom), 8'd0);
        end
    endtask

    // Random phases, each under a fresh random configuration
    task automatic test_random_traffic();
        int r;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            r = $urandom_range(0, 9);
            write_cfg(CFG_GAP, (r < 7) ? 8'($urandom_range(0, 5)) - 8'd4 : 8'($urandom));
            r = $urandom_range(0, 9);
            write_cfg(CFG_ALPHA, (r < 8) ? 8'($urandom_range(1, 16))
                                         : 8'($urandom_range(0, 31)));
            r = $urandom_range(0, 19);
            if (r < 14)
                write_cfg(CFG_LEN, 8'($urandom_range(1, 12)));
            else if (r < 17)
                write_cfg(CFG_LEN, 8'($urandom_range(13, 64)));
            else
                write_cfg(CFG_LEN, 8'($urandom_range(0, 127)));
            for (int k = 0; k < 52; k++)
            begin
                // sender holds off mid-phase until all cells are back
                if (phase == 3 && k == 26)
                    wait_idle();
                send_item(next_traffic_item());
            end
        end
    endtask

    // Receiver stall pattern, reshuffled each time the current mode runs out
    always @(posedge clk)
    begin
        case (ready_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= ready_pat[ready_phase % 32];
            default: result_ready <= ($urandom_range(0, 9) == 0);
        endcase
        ready_phase <= ready_phase + 1;
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 300);
            ready_pat <= $urandom;
        end
        else
            mode_left <= mode_left - 1;
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Compare each result transaction with the oldest expected cell
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("result transaction with no cell expected");
                errors++;
            end
            else
            begin
                want = expected_cells.pop_front();
                check_field("column", want.column, result_out.column);
                check_field("cell_score", want.cell_score, result_out.cell_score);
                check_field("direction", want.direction, result_out.direction);
                check_field("best_score", want.best_score, result_out.best_score);
                check_field("best_row", want.best_row, result_out.best_row);
                check_field("best_col", want.best_col, result_out.best_col);
                check_field("unknown_symbol", want.unknown_symbol,
                            result_out.unknown_symbol);
                check_field("last", want.last, result_out.last);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_stores();
        test_reset_defaults();
        test_commands();
        test_config_extremes();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/lsr_pkg.sv
rtl/core/lsr_ram.sv
rtl/core/lsr_alphabet.sv
rtl/core/lsr_cell.sv
rtl/core/local_alignment_row_scorer.sv
sim/tb.sv
